// ===== rtl/core/sma_pkg.sv =====
// Shared types and constants for the stack machine arithmetic unit.
package sma_pkg;

    typedef enum logic [2:0] {
        OP_PUSH = 3'd0,
        OP_SUB  = 3'd1,
        OP_DIV  = 3'd2,
        OP_MUL  = 3'd3,
        OP_MOD  = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_SHORT   = 2'd1,
        STS_DIVZERO = 2'd2,
        STS_FULL    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_EXEC,
        S_FIN
    } ctrl_state_t;

    typedef enum logic [1:0] {
        U_IDLE,
        U_RUN,
        U_FIX,
        U_DONE
    } unit_state_t;

    localparam int WORD_W = 32;
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_LAST = 5'd31;

    typedef struct packed {
        logic       start;
        logic [2:0] op;
    } iter_req_t;

endpackage

// ===== rtl/core/sma_iter_unit.sv =====
// Iterative arithmetic unit: subtract, shift-add multiply and restoring divide on one adder.
module sma_iter_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sma_pkg::iter_req_t            req,
    input  logic [sma_pkg::WORD_W-1:0]    a,
    input  logic [sma_pkg::WORD_W-1:0]    b,
    output logic                          done,
    output logic [sma_pkg::WORD_W-1:0]    result
);
    import sma_pkg::*;

    unit_state_t         state_reg, state_next;
    logic [2:0]          op_reg;
    logic [WORD_W-1:0]   acc_reg;
    logic [WORD_W-1:0]   opa_reg;
    logic [WORD_W-1:0]   opb_reg;
    logic [WORD_W-1:0]   res_reg;
    logic [STEP_W-1:0]   cnt_reg;
    logic                neg_reg;

    logic [WORD_W:0]     add_x;
    logic [WORD_W:0]     add_y;
    logic                add_sub;
    logic [WORD_W+1:0]   sum;
    logic [WORD_W-1:0]   fix_val;
    logic [WORD_W-1:0]   a_mag;
    logic [WORD_W-1:0]   b_mag;

    assign a_mag   = a[WORD_W-1] ? (WORD_W'(0) - a) : a;
    assign b_mag   = b[WORD_W-1] ? (WORD_W'(0) - b) : b;
    assign fix_val = (op_reg == OP_DIV) ? opb_reg : acc_reg;

    // The single adder; in divide steps it trial-subtracts the divisor from the shifted remainder.
    always_comb begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        unique case (state_reg)
            U_RUN: begin
                if (op_reg == OP_MUL) begin
                    add_x = {1'b0, acc_reg};
                    add_y = {1'b0, opa_reg};
                end else if (op_reg == OP_SUB) begin
                    add_x   = {1'b0, acc_reg};
                    add_y   = {1'b0, opa_reg};
                    add_sub = 1'b1;
                end else begin
                    add_x   = {acc_reg, opb_reg[WORD_W-1]};
                    add_y   = {1'b0, opa_reg};
                    add_sub = 1'b1;
                end
            end
            U_FIX: begin
                add_y   = {1'b0, fix_val};
                add_sub = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign sum = {1'b0, add_x} + ({1'b0, add_y} ^ {(WORD_W+2){add_sub}})
               + {{(WORD_W+1){1'b0}}, add_sub};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            U_IDLE: if (req.start) state_next = U_RUN;
            U_RUN: begin
                if (op_reg == OP_SUB) begin
                    state_next = U_DONE;
                end else if (cnt_reg == STEP_LAST) begin
                    state_next = U_FIX;
                end
            end
            U_FIX:  state_next = U_DONE;
            U_DONE: state_next = U_IDLE;
            default: state_next = U_IDLE;
        endcase
    end

    always_comb begin
        done = 1'b0;
        unique case (state_reg)
            U_DONE:  done = 1'b1;
            default: done = 1'b0;
        endcase
    end

    assign result = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= U_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            U_IDLE: begin
                if (req.start) begin
                    op_reg  <= req.op;
                    cnt_reg <= '0;
                    if (req.op == OP_SUB) begin
                        acc_reg <= a;
                        opa_reg <= b;
                        neg_reg <= 1'b0;
                    end else if (req.op == OP_MUL) begin
                        acc_reg <= '0;
                        opa_reg <= a;
                        opb_reg <= b;
                        neg_reg <= 1'b0;
                    end else begin
                        acc_reg <= '0;
                        opa_reg <= b_mag;
                        opb_reg <= a_mag;
                        // Quotient sign follows both operands, remainder sign the dividend.
                        neg_reg <= (req.op == OP_DIV) ? (a[WORD_W-1] ^ b[WORD_W-1])
                                                      : a[WORD_W-1];
                    end
                end
            end
            U_RUN: begin
                cnt_reg <= cnt_reg + STEP_W'(1);
                if (op_reg == OP_SUB) begin
                    res_reg <= sum[WORD_W-1:0];
                end else if (op_reg == OP_MUL) begin
                    if (opb_reg[0]) acc_reg <= sum[WORD_W-1:0];
                    opa_reg <= {opa_reg[WORD_W-2:0], 1'b0};
                    opb_reg <= {1'b0, opb_reg[WORD_W-1:1]};
                end else begin
                    if (!sum[WORD_W+1]) begin
                        acc_reg <= sum[WORD_W-1:0];
                        opb_reg <= {opb_reg[WORD_W-2:0], 1'b1};
                    end else begin
                        acc_reg <= {acc_reg[WORD_W-2:0], opb_reg[WORD_W-1]};
                        opb_reg <= {opb_reg[WORD_W-2:0], 1'b0};
                    end
                end
            end
            U_FIX: begin
                res_reg <= neg_reg ? sum[WORD_W-1:0] : fix_val;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/core/stack_machine_arith_unit_core.sv =====
// Top level of the stack machine arithmetic unit: control sequencer, stack memory, result register.
//
// Channel  | Dir | Ports                        | Contents
// ---------+-----+------------------------------+--------------------------------------------
// input    | in  | s_tvalid s_tready s_tdata    | tuser: opcode; tdata: push_value
//          |     | s_tuser                      |
// result   | out | m_tvalid m_tready m_tdata    | tuser: status; tdata: top_value, depth
//          |     | m_tuser                      |
//
// One item is worked on at a time and s_tready is high only while the sequencer is idle.
// A push, an unknown opcode or a rejected operation goes from decode straight to the finish
// state; an accepted sub, mul, div or mod passes through read and execute, and mul, div and mod
// take the 32 steps of the shared adder inside the iterative unit plus its sign fix-up step.
// Reset (aresetn low at a rising edge of aclk) empties the stack and drops any pending result;
// stack memory contents are left as they are and only entries below the depth are ever read.
// The result sits in an output register, so a new input transfer is taken while the previous
// result still waits for m_tready; a finished item waits only if that register is still full.
module stack_machine_arith_unit_core #(
    parameter int STACK_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] push_value
    input  logic [2:0]  s_tuser,   // [2:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] top_value, [38:32] depth, [39] zero
    output logic [1:0]  m_tuser    // [1:0] status
);
    import sma_pkg::*;

    // Count holds 0 to STACK_DEPTH; memory addresses cover 0 to STACK_DEPTH-1.
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    ctrl_state_t         state_reg, state_next;
    logic [2:0]          op_reg;
    logic [WORD_W-1:0]   pv_reg;
    logic [1:0]          status_reg;
    logic [CW-1:0]       count_reg;
    logic [WORD_W-1:0]   top_reg;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [39:0]         m_tdata_reg;
    logic [1:0]          m_tuser_reg;

    // Stack memory: one write port, one registered read port.
    logic [WORD_W-1:0]   mem [STACK_DEPTH];
    logic [WORD_W-1:0]   rd_data_reg;
    logic                mem_we;
    logic                mem_re;
    logic [AW-1:0]       mem_waddr;
    logic [WORD_W-1:0]   mem_wdata;

    logic [CW-1:0]       sec_idx_full;
    logic [AW-1:0]       sec_idx;
    logic [AW-1:0]       push_idx;
    logic                is_arith;
    logic                is_divmod;
    logic                is_full;
    logic                is_short;
    logic                is_divzero;
    logic                push_ok;
    logic                arith_go;
    logic [1:0]          dec_status;
    logic                out_free;
    logic [CW+6:0]       count_wide;
    logic [WORD_W-1:0]   top_out;

    iter_req_t           unit_req;
    logic                unit_done;
    logic [WORD_W-1:0]   unit_result;

    sma_iter_unit u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (unit_req),
        .a       (rd_data_reg),
        .b       (top_reg),
        .done    (unit_done),
        .result  (unit_result)
    );

    // The second entry sits just below the cached top; a push lands at the current count.
    assign sec_idx_full = count_reg - CW'(2);
    assign sec_idx      = sec_idx_full[AW-1:0];
    assign push_idx     = count_reg[AW-1:0];

    // Decode of the latched item against the current stack. The length check wins over
    // the zero-divisor check.
    assign is_arith   = (op_reg == OP_SUB) || (op_reg == OP_DIV) ||
                        (op_reg == OP_MUL) || (op_reg == OP_MOD);
    assign is_divmod  = (op_reg == OP_DIV) || (op_reg == OP_MOD);
    assign is_full    = (count_reg == CW'(STACK_DEPTH));
    assign is_short   = is_arith && (count_reg < CW'(2));
    assign is_divzero = is_divmod && !is_short && (top_reg == WORD_W'(0));
    assign push_ok    = (op_reg == OP_PUSH) && !is_full;
    assign arith_go   = is_arith && !is_short && !is_divzero;

    always_comb begin
        if ((op_reg == OP_PUSH) && is_full) begin
            dec_status = STS_FULL;
        end else if (is_short) begin
            dec_status = STS_SHORT;
        end else if (is_divzero) begin
            dec_status = STS_DIVZERO;
        end else begin
            dec_status = STS_OK;
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (s_tvalid) state_next = S_DECODE;
            S_DECODE: state_next = arith_go ? S_READ : S_FIN;
            S_READ:   state_next = S_EXEC;
            S_EXEC:   if (unit_done) state_next = S_FIN;
            S_FIN:    if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Output logic of the sequencer: memory port, unit start and input ready.
    always_comb begin
        s_tready       = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = push_idx;
        mem_wdata      = pv_reg;
        unit_req.start = 1'b0;
        unit_req.op    = op_reg;
        unique case (state_reg)
            S_IDLE: s_tready = 1'b1;
            S_DECODE: begin
                mem_we = push_ok;
                mem_re = arith_go;
            end
            S_READ: unit_req.start = 1'b1;
            S_EXEC: begin
                mem_we    = unit_done;
                mem_waddr = sec_idx;
                mem_wdata = unit_result;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (mem_re) rd_data_reg <= mem[sec_idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if ((state_reg == S_DECODE) && push_ok) begin
                count_reg <= count_reg + CW'(1);
            end else if ((state_reg == S_EXEC) && unit_done) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    // Item, status and cached top of stack; payload only, no reset needed.
    always_ff @(posedge aclk) begin
        if ((state_reg == S_IDLE) && s_tvalid) begin
            op_reg <= s_tuser;
            pv_reg <= s_tdata;
        end
        if (state_reg == S_DECODE) begin
            status_reg <= dec_status;
            if (push_ok) top_reg <= pv_reg;
        end
        if ((state_reg == S_EXEC) && unit_done) top_reg <= unit_result;
    end

    // Result register: loaded once the stack reflects the finished item.
    assign count_wide = {7'd0, count_reg};
    assign top_out    = (count_reg != CW'(0)) ? top_reg : WORD_W'(0);

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if ((state_reg == S_FIN) && out_free) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == S_FIN) && out_free) begin
            m_tdata_reg <= {1'b0, count_wide[6:0], top_out};
            m_tuser_reg <= status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTH
    // The stack never holds more entries than it has room for.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count above depth");

    // The arithmetic unit finishes only while the sequencer waits for it.
    a_done_in_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        unit_done |-> (state_reg == S_EXEC))
        else $error("arithmetic unit finished outside execute");

    // Leaving the finish state always leaves a result waiting on the output.
    a_fin_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_FIN) && out_free) |=> m_tvalid)
        else $error("finished item produced no result");
`endif

endmodule
